FILE: rtl/aohm_pkg.sv
package aohm_pkg;

  // Range count and the highest range the 2-bit range state can hold
  localparam int NUM_RANGES = 4;
  localparam int NUM_GAINS  = 4;
  localparam logic [1:0] TOP_RANGE = (NUM_RANGES > 4) ? 2'd3 : 2'(NUM_RANGES - 1);

  // Field widths
  localparam int CODE_W  = 16;
  localparam int MAG_W   = 15;
  localparam int GAIN_W  = 16;
  localparam int WIN_W   = 15;
  localparam int LIMIT_W = 16;
  localparam int RES_W   = 32;
  localparam int KOHM_W  = 14;
  localparam int OHM_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Datapath widths: product of (32768 - code), gain and decade scale stays below 2^51
  localparam int SCALE_W = 20;
  localparam int ACC_W   = 52;
  localparam int RND_SH  = 15;
  localparam int QUO_W   = ACC_W - RND_SH;

  // Step counts of the shift-add multiplier and the restoring divider
  localparam int MUL_STEPS = SCALE_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  // Divisors for the decimal split
  localparam logic [MAG_W-1:0] DIV_KILO  = MAG_W'(1000);
  localparam logic [MAG_W-1:0] DIV_DEC4  = MAG_W'(10000);

  localparam logic [RES_W-1:0] SAT32 = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN0       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN1       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN2       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN3       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_LIMIT  = 3'd6;

  // Reset values
  localparam logic [GAIN_W-1:0] GAIN_RESET [NUM_GAINS] = '{
    16'd32309, 16'd31949, 16'd32768, 16'd21889
  };
  localparam logic [WIN_W-1:0]   WINDOW_LOW_RESET  = 15'd8000;
  localparam logic [WIN_W-1:0]   WINDOW_HIGH_RESET = 15'd24000;
  localparam logic [LIMIT_W-1:0] BEEP_LIMIT_RESET  = 16'd80;

  function automatic logic [SCALE_W-1:0] decade_scale(input logic [1:0] rng);
    logic [SCALE_W-1:0] s;
    case (rng)
      2'd0:    s = 20'd1000;
      2'd1:    s = 20'd10000;
      2'd2:    s = 20'd100000;
      default: s = 20'd1000000;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/autorange_ohmmeter.sv
// Autoranging ohmmeter: each beat on the input channel is one signed ADC code taken on the
// range now held; each produces one result beat. A code inside the window (or at an end
// range) settles and yields the rounded resistance, its kilo and unit display digits, the
// continuity beep and the over-range flag; otherwise the range steps by one and the result
// is unsettled. A range step goes straight to the finish state. A settled reading runs
// 40 steps of one bit-serial shift-add multiplier (gain, then decade scale), one
// rounding step, and three 37-step passes of one restoring divider that yields the
// resistance, then its split by 1000 and by 10000. An open circuit (code zero or below)
// skips the multiply and the first pass. One reading is in work at a time; a finished
// result waits in the output register while the next code is taken.
module autorange_ohmmeter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [aohm_pkg::CODE_W-1:0]  in_adc_code,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_settled,
  output logic [1:0]                          out_range_select,
  output logic [aohm_pkg::RES_W-1:0]          out_resistance_ohms,
  output logic [aohm_pkg::KOHM_W-1:0]         out_kohm_digits,
  output logic [aohm_pkg::OHM_W-1:0]          out_ohm_digits,
  output logic                                out_beep,
  output logic                                out_over_range,
  input  logic                                cfg_we,
  input  logic [aohm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aohm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  // Configuration
  logic [aohm_pkg::GAIN_W-1:0]  gain_r [aohm_pkg::NUM_GAINS];
  logic [aohm_pkg::WIN_W-1:0]   wlow_r, whigh_r;
  logic [aohm_pkg::LIMIT_W-1:0] blim_r;

  // Control
  logic [2:0]                   state_r, state_nxt;
  logic [aohm_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [1:0]                   pass_r, pass_nxt;
  logic [1:0]                   range_r, range_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // Datapath
  logic [aohm_pkg::MAG_W-1:0]   code_r, code_nxt;
  logic [aohm_pkg::ACC_W-1:0]   mcand_r, mcand_nxt;
  logic [aohm_pkg::SCALE_W-1:0] mplr_r, mplr_nxt;
  logic [aohm_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [aohm_pkg::QUO_W-1:0]   quo_r, quo_nxt;
  logic [aohm_pkg::MAG_W-1:0]   rem_r, rem_nxt;
  logic [aohm_pkg::MAG_W-1:0]   dvsr_r, dvsr_nxt;
  logic                         stl_r, stl_nxt;
  logic                         ovr_r, ovr_nxt;
  logic [aohm_pkg::RES_W-1:0]   res_r, res_nxt;
  logic [aohm_pkg::OHM_W-1:0]   ohm_r, ohm_nxt;
  logic [aohm_pkg::KOHM_W-1:0]  kohm_r, kohm_nxt;

  // Output register
  logic                         o_stl_r, o_stl_nxt;
  logic [1:0]                   o_rng_r, o_rng_nxt;
  logic [aohm_pkg::RES_W-1:0]   o_res_r, o_res_nxt;
  logic [aohm_pkg::KOHM_W-1:0]  o_kohm_r, o_kohm_nxt;
  logic [aohm_pkg::OHM_W-1:0]   o_ohm_r, o_ohm_nxt;
  logic                         o_beep_r, o_beep_nxt;
  logic                         o_ovr_r, o_ovr_nxt;

  // Combinational helpers
  logic signed [aohm_pkg::CODE_W-1:0] wl_s, wh_s;
  logic                         is_low, is_high, settle, code_pos;
  logic [1:0]                   r_cur;
  logic [aohm_pkg::CODE_W-1:0]  diff;
  logic [aohm_pkg::ACC_W-1:0]   sum_w, rnd_sum;
  logic [aohm_pkg::MAG_W:0]     trial, trial_sub;
  logic                         ge;
  logic [aohm_pkg::MAG_W-1:0]   rem_step;
  logic [aohm_pkg::QUO_W-1:0]   quo_step;
  logic                         sat;
  logic [aohm_pkg::RES_W-1:0]   res_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < aohm_pkg::NUM_GAINS; i++) begin
        gain_r[i] <= aohm_pkg::GAIN_RESET[i];
      end
      wlow_r  <= aohm_pkg::WINDOW_LOW_RESET;
      whigh_r <= aohm_pkg::WINDOW_HIGH_RESET;
      blim_r  <= aohm_pkg::BEEP_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        aohm_pkg::REG_GAIN0, aohm_pkg::REG_GAIN1,
        aohm_pkg::REG_GAIN2, aohm_pkg::REG_GAIN3: gain_r[cfg_index[1:0]] <= cfg_data;
        aohm_pkg::REG_WINDOW_LOW:  wlow_r  <= cfg_data[aohm_pkg::WIN_W-1:0];
        aohm_pkg::REG_WINDOW_HIGH: whigh_r <= cfg_data[aohm_pkg::WIN_W-1:0];
        aohm_pkg::REG_BEEP_LIMIT:  blim_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    // Window decisions on the incoming code
    wl_s     = $signed({1'b0, wlow_r});
    wh_s     = $signed({1'b0, whigh_r});
    is_low   = in_adc_code <= wl_s;
    is_high  = in_adc_code >= wh_s;
    r_cur    = (range_r > aohm_pkg::TOP_RANGE) ? aohm_pkg::TOP_RANGE : range_r;
    settle   = (!is_low && !is_high) || (is_low && r_cur == aohm_pkg::TOP_RANGE) ||
               (is_high && r_cur == 2'd0);
    code_pos = !in_adc_code[aohm_pkg::CODE_W-1] && (in_adc_code != '0);
    diff     = 16'h8000 - {1'b0, in_adc_code[aohm_pkg::MAG_W-1:0]};

    // Shift-add step
    sum_w   = acc_r + (mplr_r[0] ? mcand_r : '0);
    rnd_sum = acc_r + {{(aohm_pkg::ACC_W - aohm_pkg::MAG_W - 14){1'b0}}, code_r, 14'd0};

    // Restoring division step
    trial     = {rem_r, quo_r[aohm_pkg::QUO_W-1]};
    trial_sub = trial - {1'b0, dvsr_r};
    ge        = trial >= {1'b0, dvsr_r};
    rem_step  = ge ? trial_sub[aohm_pkg::MAG_W-1:0] : trial[aohm_pkg::MAG_W-1:0];
    quo_step  = {quo_r[aohm_pkg::QUO_W-2:0], ge};
    sat       = |quo_step[aohm_pkg::QUO_W-1:aohm_pkg::RES_W];
    res_val   = sat ? aohm_pkg::SAT32 : quo_step[aohm_pkg::RES_W-1:0];

    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pass_nxt  = pass_r;
    range_nxt = range_r;
    code_nxt  = code_r;
    mcand_nxt = mcand_r;
    mplr_nxt  = mplr_r;
    acc_nxt   = acc_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvsr_nxt  = dvsr_r;
    stl_nxt   = stl_r;
    ovr_nxt   = ovr_r;
    res_nxt   = res_r;
    ohm_nxt   = ohm_r;
    kohm_nxt  = kohm_r;

    out_valid_nxt = out_valid_r && !out_ready;
    o_stl_nxt  = o_stl_r;
    o_rng_nxt  = o_rng_r;
    o_res_nxt  = o_res_r;
    o_kohm_nxt = o_kohm_r;
    o_ohm_nxt  = o_ohm_r;
    o_beep_nxt = o_beep_r;
    o_ovr_nxt  = o_ovr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          code_nxt = in_adc_code[aohm_pkg::MAG_W-1:0];
          cnt_nxt  = '0;
          if (!settle) begin
            if (is_low) begin
              range_nxt = (r_cur < aohm_pkg::TOP_RANGE) ? r_cur + 2'd1 : r_cur;
            end else begin
              range_nxt = (r_cur > 2'd0) ? r_cur - 2'd1 : r_cur;
            end
            stl_nxt   = 1'b0;
            ovr_nxt   = 1'b0;
            res_nxt   = '0;
            ohm_nxt   = '0;
            kohm_nxt  = '0;
            state_nxt = ST_FIN;
          end else begin
            range_nxt = r_cur;
            stl_nxt   = 1'b1;
            if (code_pos) begin
              mcand_nxt = {{(aohm_pkg::ACC_W - aohm_pkg::CODE_W){1'b0}}, diff};
              mplr_nxt  = {{(aohm_pkg::SCALE_W - aohm_pkg::GAIN_W){1'b0}}, gain_r[r_cur]};
              acc_nxt   = '0;
              state_nxt = ST_MUL1;
            end else begin
              // open circuit: saturate and go straight to the digit split
              res_nxt   = aohm_pkg::SAT32;
              ovr_nxt   = 1'b1;
              quo_nxt   = {{(aohm_pkg::QUO_W - aohm_pkg::RES_W){1'b0}}, aohm_pkg::SAT32};
              rem_nxt   = '0;
              dvsr_nxt  = aohm_pkg::DIV_KILO;
              pass_nxt  = 2'd1;
              state_nxt = ST_DIV;
            end
          end
        end
      end
      ST_MUL1: begin
        mcand_nxt = {mcand_r[aohm_pkg::ACC_W-2:0], 1'b0};
        mplr_nxt  = {1'b0, mplr_r[aohm_pkg::SCALE_W-1:1]};
        acc_nxt   = sum_w;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == aohm_pkg::MUL_LAST) begin
          // product so far becomes the multiplicand of the decade scale
          mcand_nxt = sum_w;
          mplr_nxt  = aohm_pkg::decade_scale(range_r);
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        mcand_nxt = {mcand_r[aohm_pkg::ACC_W-2:0], 1'b0};
        mplr_nxt  = {1'b0, mplr_r[aohm_pkg::SCALE_W-1:1]};
        acc_nxt   = sum_w;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == aohm_pkg::MUL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_RND;
        end
      end
      ST_RND: begin
        // add half the denominator, then drop the 2^15 factor of it
        quo_nxt   = rnd_sum[aohm_pkg::ACC_W-1:aohm_pkg::RND_SH];
        rem_nxt   = '0;
        dvsr_nxt  = code_r;
        pass_nxt  = 2'd0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        quo_nxt = quo_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == aohm_pkg::DIV_LAST) begin
          cnt_nxt = '0;
          rem_nxt = '0;
          case (pass_r)
            2'd0: begin
              res_nxt  = res_val;
              ovr_nxt  = sat;
              quo_nxt  = {{(aohm_pkg::QUO_W - aohm_pkg::RES_W){1'b0}}, res_val};
              dvsr_nxt = aohm_pkg::DIV_KILO;
              pass_nxt = 2'd1;
            end
            2'd1: begin
              ohm_nxt  = rem_step[aohm_pkg::OHM_W-1:0];
              dvsr_nxt = aohm_pkg::DIV_DEC4;
              pass_nxt = 2'd2;
            end
            default: begin
              kohm_nxt  = rem_step[aohm_pkg::KOHM_W-1:0];
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_stl_nxt  = stl_r;
          o_rng_nxt  = range_r;
          o_res_nxt  = res_r;
          o_kohm_nxt = kohm_r;
          o_ohm_nxt  = ohm_r;
          o_beep_nxt = stl_r &&
                       (res_r <= {{(aohm_pkg::RES_W - aohm_pkg::LIMIT_W){1'b0}}, blim_r});
          o_ovr_nxt  = ovr_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pass_r      <= '0;
      range_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pass_r      <= pass_nxt;
      range_r     <= range_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r   <= code_nxt;
    mcand_r  <= mcand_nxt;
    mplr_r   <= mplr_nxt;
    acc_r    <= acc_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    dvsr_r   <= dvsr_nxt;
    stl_r    <= stl_nxt;
    ovr_r    <= ovr_nxt;
    res_r    <= res_nxt;
    ohm_r    <= ohm_nxt;
    kohm_r   <= kohm_nxt;
    o_stl_r  <= o_stl_nxt;
    o_rng_r  <= o_rng_nxt;
    o_res_r  <= o_res_nxt;
    o_kohm_r <= o_kohm_nxt;
    o_ohm_r  <= o_ohm_nxt;
    o_beep_r <= o_beep_nxt;
    o_ovr_r  <= o_ovr_nxt;
  end

  assign in_ready            = (state_r == ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_settled         = o_stl_r;
  assign out_range_select    = o_rng_r;
  assign out_resistance_ohms = o_res_r;
  assign out_kohm_digits     = o_kohm_r;
  assign out_ohm_digits      = o_ohm_r;
  assign out_beep            = o_beep_r;
  assign out_over_range      = o_ovr_r;

  a_unsettled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_settled) |->
      (out_resistance_ohms == '0 && !out_beep && !out_over_range))
    else $error("unsettled result carries a reading");

  a_beep_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beep) |-> (out_settled && !out_over_range))
    else $error("beep without a settled in-range reading");

  a_over_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_over_range) |-> (out_resistance_ohms == aohm_pkg::SAT32))
    else $error("over range without saturated resistance");

  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ohm_digits < 10'd1000 && out_kohm_digits < 14'd10000 &&
                   out_range_select <= aohm_pkg::TOP_RANGE))
    else $error("display digits or range out of bounds");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again before the reading finished");

endmodule

FILE: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIR_N        = 25;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 66;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 200;
  localparam int PHASE_RESET  = PHASES - 1;

  localparam logic [aohm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // receiver stall modes
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

  localparam longint unsigned DECADE [4] = '{64'd1000, 64'd10000, 64'd100000, 64'd1000000};

  typedef struct packed {
    logic                        settled;
    logic [1:0]                  range_select;
    logic [aohm_pkg::RES_W-1:0]  ohms;
    logic [aohm_pkg::KOHM_W-1:0] kohm;
    logic [aohm_pkg::OHM_W-1:0]  ohm;
    logic                        beep;
    logic                        over_range;
  } reading_t;

  typedef struct packed {
    logic [aohm_pkg::CODE_W-1:0] code;
    logic                        typed;
    reading_t                    want;
  } stim_row_t;

  function automatic reading_t moved(logic [1:0] r);
    reading_t m;
    m = '0;
    m.range_select = r;
    return m;
  endfunction

  localparam reading_t NONE    = '0;
  localparam reading_t OPEN_R3 = '{1'b1, 2'd3, 32'hFFFF_FFFF, 14'd4967, 10'd295, 1'b0, 1'b1};
  localparam reading_t SHORT_R0 = '{1'b1, 2'd0, 32'd0, 14'd0, 10'd0, 1'b1, 1'b0};
  localparam reading_t EXACT_R2 = '{1'b1, 2'd2, 32'd100000, 14'd100, 10'd0, 1'b0, 1'b0};

  // walks up to the top range, exercises open circuit and overflow there, then the window
  // edges on ranges 3, 1 and 0 and an exact reading on range 2 with the reset calibration
  localparam stim_row_t DIRECTED_ROWS [DIR_N] = '{
    '{16'd0,     1'b1, moved(2'd1)},
    '{16'h8000,  1'b1, moved(2'd2)},
    '{16'd0,     1'b1, moved(2'd3)},
    '{16'hFFFF,  1'b1, OPEN_R3},
    '{16'h8000,  1'b1, OPEN_R3},
    '{16'd1,     1'b1, OPEN_R3},
    '{16'd8000,  1'b0, NONE},
    '{16'd8001,  1'b0, NONE},
    '{16'd23999, 1'b0, NONE},
    '{16'd24000, 1'b1, moved(2'd2)},
    '{16'd32767, 1'b1, moved(2'd1)},
    '{16'd24000, 1'b1, moved(2'd0)},
    '{16'd32767, 1'b1, SHORT_R0},
    '{16'd24000, 1'b0, NONE},
    '{16'd8001,  1'b0, NONE},
    '{16'd8000,  1'b1, moved(2'd1)},
    '{16'd16384, 1'b0, NONE},
    '{16'd100,   1'b1, moved(2'd2)},
    '{16'd16000, 1'b0, NONE},
    '{16'd16384, 1'b1, EXACT_R2},
    '{16'hFFFE,  1'b1, moved(2'd3)},
    '{16'd20000, 1'b0, NONE},
    '{16'd32767, 1'b1, moved(2'd2)},
    '{16'd32767, 1'b1, moved(2'd1)},
    '{16'd12000, 1'b0, NONE}
  };

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic signed [aohm_pkg::CODE_W-1:0]  in_adc_code;
  logic                                out_valid;
  logic                                out_ready;
  logic                                out_settled;
  logic [1:0]                          out_range_select;
  logic [aohm_pkg::RES_W-1:0]          out_resistance_ohms;
  logic [aohm_pkg::KOHM_W-1:0]         out_kohm_digits;
  logic [aohm_pkg::OHM_W-1:0]          out_ohm_digits;
  logic                                out_beep;
  logic                                out_over_range;
  logic                                cfg_we;
  logic [aohm_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [aohm_pkg::CFG_DATA_W-1:0]     cfg_data;

  autorange_ohmmeter DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_adc_code         (in_adc_code),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_settled         (out_settled),
    .out_range_select    (out_range_select),
    .out_resistance_ohms (out_resistance_ohms),
    .out_kohm_digits     (out_kohm_digits),
    .out_ohm_digits      (out_ohm_digits),
    .out_beep            (out_beep),
    .out_over_range      (out_over_range),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // meter state as the block should hold it
  logic [1:0]                   range_now = 2'd0;
  logic [aohm_pkg::GAIN_W-1:0]  gain_tab [aohm_pkg::NUM_GAINS] = aohm_pkg::GAIN_RESET;
  logic [aohm_pkg::WIN_W-1:0]   win_low_r  = aohm_pkg::WINDOW_LOW_RESET;
  logic [aohm_pkg::WIN_W-1:0]   win_high_r = aohm_pkg::WINDOW_HIGH_RESET;
  logic [aohm_pkg::LIMIT_W-1:0] beep_lim_r = aohm_pkg::BEEP_LIMIT_RESET;

  stim_row_t queued_codes [$];
  reading_t  pending_readings [$];
  int        errors = 0;
  int        idle_cycles = 0;

  function automatic reading_t predict_reading(logic signed [aohm_pkg::CODE_W-1:0] code);
    int              c;
    int              lo;
    int              hi;
    logic [1:0]      r;
    logic            low;
    logic            settle;
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    reading_t        res;
    c  = code;
    lo = win_low_r;
    hi = win_high_r;
    r  = (range_now > aohm_pkg::TOP_RANGE) ? aohm_pkg::TOP_RANGE : range_now;
    res = '0;
    low = (c <= lo);
    settle = (c > lo && c < hi) || (low && r == aohm_pkg::TOP_RANGE) ||
             (c >= hi && r == 2'd0);
    if (!settle) begin
      if (low) begin
        if (r < aohm_pkg::TOP_RANGE) r = r + 2'd1;
      end else if (r > 2'd0) begin
        r = r - 2'd1;
      end
    end else begin
      res.settled = 1'b1;
      if (c <= 0) begin
        // open circuit
        res.ohms = '1;
        res.over_range = 1'b1;
      end else begin
        num = DECADE[r] * longint'(32768 - c) * longint'(gain_tab[r]);
        den = longint'(c) * 64'd32768;
        q = (num + den / 2) / den;
        if (q > 64'hFFFF_FFFF) begin
          res.ohms = '1;
          res.over_range = 1'b1;
        end else begin
          res.ohms = q[aohm_pkg::RES_W-1:0];
        end
      end
      res.beep = (res.ohms <= beep_lim_r);
    end
    range_now = r;
    res.range_select = r;
    res.kohm = aohm_pkg::KOHM_W'((res.ohms / 1000) % 10000);
    res.ohm  = aohm_pkg::OHM_W'(res.ohms % 1000);
    return res;
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    stim_row_t row;
    reading_t  pred;
    reading_t  want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        row  = queued_codes.pop_front();
        pred = predict_reading(in_adc_code);
        pending_readings.push_back(row.typed ? row.want : pred);
      end
      if (out_valid && out_ready) begin
        if (pending_readings.size() == 0) begin
          $error("result beat with no reading outstanding");
          errors++;
        end else begin
          want = pending_readings.pop_front();
          check_field("settled", want.settled, out_settled);
          check_field("range_select", want.range_select, out_range_select);
          check_field("resistance_ohms", want.ohms, out_resistance_ohms);
          check_field("kohm_digits", want.kohm, out_kohm_digits);
          check_field("ohm_digits", want.ohm, out_ohm_digits);
          check_field("beep", want.beep, out_beep);
          check_field("over_range", want.over_range, out_over_range);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("autorange_ohmmeter regression: fail");
        $finish;
      end
    end
  end

  // receiver: stall pattern picked anew at random
  rx_mode_t rx_mode = RX_FREE;
  int       rx_left = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(1, 40);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= 1'b0;
    endcase
  end

  task automatic send_row(stim_row_t row);
    queued_codes.push_back(row);
    @(negedge clk);
    in_valid    <= 1'b1;
    in_adc_code <= row.code;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_sender(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // hold the sender until every outstanding reading is back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (queued_codes.size() != 0 || pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [aohm_pkg::CFG_IDX_W-1:0] idx,
                           logic [aohm_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      aohm_pkg::REG_GAIN0, aohm_pkg::REG_GAIN1,
      aohm_pkg::REG_GAIN2, aohm_pkg::REG_GAIN3: gain_tab[idx[1:0]] = data;
      aohm_pkg::REG_WINDOW_LOW:  win_low_r  = data[aohm_pkg::WIN_W-1:0];
      aohm_pkg::REG_WINDOW_HIGH: win_high_r = data[aohm_pkg::WIN_W-1:0];
      aohm_pkg::REG_BEEP_LIMIT:  beep_lim_r = data;
      default: ;
    endcase
  endtask

  task automatic configure(int phase);
    logic [aohm_pkg::GAIN_W-1:0]     g [aohm_pkg::NUM_GAINS];
    logic [aohm_pkg::CFG_DATA_W-1:0] lo;
    logic [aohm_pkg::CFG_DATA_W-1:0] hi;
    logic [aohm_pkg::CFG_DATA_W-1:0] bl;
    for (int i = 0; i < aohm_pkg::NUM_GAINS; i++) g[i] = 16'($urandom());
    bl = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 2000)) : 16'($urandom());
    lo = 16'($urandom_range(0, 16000));
    hi = 16'($urandom_range(int'(lo) + 1, 32767));
    case (phase)
      0: begin
        g  = '{default: 16'hFFFF};
        lo = '0;
        hi = 16'h7FFF;
        bl = 16'hFFFF;
      end
      1: begin
        // inverted window, top bit of the window data must be dropped
        g  = '{default: 16'h0000};
        lo = 16'hFFFF;
        hi = '0;
        bl = '0;
      end
      2: begin
        lo = 16'($urandom_range(1, 32767));
        hi = lo;
        write_reg(REG_UNUSED, 16'($urandom()));
      end
      PHASE_RESET: begin
        g  = aohm_pkg::GAIN_RESET;
        lo = 16'(aohm_pkg::WINDOW_LOW_RESET);
        hi = 16'(aohm_pkg::WINDOW_HIGH_RESET);
        bl = aohm_pkg::BEEP_LIMIT_RESET;
      end
      default: ;
    endcase
    write_reg(aohm_pkg::REG_GAIN0, g[0]);
    write_reg(aohm_pkg::REG_GAIN1, g[1]);
    write_reg(aohm_pkg::REG_GAIN2, g[2]);
    write_reg(aohm_pkg::REG_GAIN3, g[3]);
    write_reg(aohm_pkg::REG_WINDOW_LOW, lo);
    write_reg(aohm_pkg::REG_WINDOW_HIGH, hi);
    write_reg(aohm_pkg::REG_BEEP_LIMIT, bl);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [aohm_pkg::CODE_W-1:0] pick_code();
    int lo;
    int hi;
    int c;
    lo = win_low_r;
    hi = win_high_r;
    case ($urandom_range(0, 9))
      0, 1: c = $urandom_range(0, 65535);
      2, 3, 4: begin
        if (lo + 1 <= hi - 1) c = $urandom_range(lo + 1, hi - 1);
        else c = $urandom_range(0, 32767);
      end
      5: c = $urandom_range(0, lo);
      6: c = $urandom_range(hi, 32767);
      7: c = $urandom_range(1, 64);
      8: begin
        case ($urandom_range(0, 3))
          0: c = lo;
          1: c = lo + 1;
          2: c = hi;
          default: c = hi - 1;
        endcase
      end
      default: c = -int'($urandom_range(0, 32768));
    endcase
    return c[aohm_pkg::CODE_W-1:0];
  endfunction

  initial begin
    stim_row_t row;
    int        sent;
    int        blen;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_adc_code = '0;
    out_ready   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      send_row(DIRECTED_ROWS[i]);
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 8));
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      configure(p);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        blen = $urandom_range(1, 24);
        for (int k = 0; k < blen && sent < PHASE_ITEMS; k++) begin
          row = '{pick_code(), 1'b0, NONE};
          send_row(row);
          sent++;
        end
        if ($urandom_range(0, 39) == 0) drain();
        else if ($urandom_range(0, 3) == 0) pause_sender(0);
        else if ($urandom_range(0, 7) == 0) pause_sender($urandom_range(13, 200));
        else pause_sender($urandom_range(1, 12));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_readings.size() != 0) begin
      $error("%0d readings never returned", pending_readings.size());
      errors++;
    end
    if (errors == 0) begin
      $display("autorange_ohmmeter regression: pass");
    end else begin
      $display("autorange_ohmmeter regression: fail");
    end
    $finish;
  end

endmodule
